FILE: sv/lpr_pkg.sv
package lpr_pkg;

   // Default geometry.
   localparam int FRAMES_DEF    = 8;
   localparam int PAGE_BITS_DEF = 8;

   // Fixed port widths.
   localparam int PAGE_W  = 8;
   localparam int FRAME_W = 3;
   localparam int INDEX_W = 16;
   localparam int CSR_W   = 4;

   localparam logic [CSR_W-1:0] LIMIT_RESET = CSR_W'(8);

   // Per-cell control from the chain controller.
   typedef struct packed {
      logic load;   // take the neighbor's entry this cycle
      logic live;   // cell position is below the occupancy count
   } cell_ctl_type;

endpackage

FILE: sv/lpr_cell.sv
module lpr_cell #(
   parameter int PAGE_BITS = lpr_pkg::PAGE_BITS_DEF,
   parameter int FIDX_W    = 3
) (
   input  logic                     clock,
   input  lpr_pkg::cell_ctl_type    ctl,
   input  logic [PAGE_BITS-1:0]     key,
   input  logic [PAGE_BITS-1:0]     up_page,
   input  logic [FIDX_W-1:0]        up_frame,
   output logic                     match,
   output logic [PAGE_BITS-1:0]     page,
   output logic [FIDX_W-1:0]        frame
);

   logic [PAGE_BITS-1:0] page_ff, page_in;
   logic [FIDX_W-1:0]    frame_ff, frame_in;

   assign page_in  = ctl.load ? up_page  : page_ff;
   assign frame_in = ctl.load ? up_frame : frame_ff;

   always_ff @(posedge clock) begin
      page_ff  <= page_in;
      frame_ff <= frame_in;
   end

   assign match = ctl.live && (page_ff == key);
   assign page  = page_ff;
   assign frame = frame_ff;

endmodule

FILE: sv/lru_page_replacement.sv
// The result word is registered at the edge that takes the request.
// Throughput: one request word per cycle; the output register drains while the next
// request is taken, and the request side stalls while a result waits under stall or reset is high.
// The recency stack is one pass through the cell chain per request (parallel match).
// Reset (synchronous, active high): occupancy, request counter and output valid clear,
// the frame limit returns to 8; cell contents are not cleared.
module lru_page_replacement #(
   parameter int FRAMES    = lpr_pkg::FRAMES_DEF,
   parameter int PAGE_BITS = lpr_pkg::PAGE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // request word
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [lpr_pkg::PAGE_W-1:0]    req_page,
   // result word
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_hit,
   output logic                          rsp_evicted,
   output logic                          rsp_frame_valid,
   output logic [lpr_pkg::FRAME_W-1:0]   rsp_frame,
   output logic [lpr_pkg::INDEX_W-1:0]   rsp_request_index,
   output logic [lpr_pkg::PAGE_W-1:0]    rsp_page_out,
   // frame limit register
   input  logic                          csr_wr_en,
   input  logic [lpr_pkg::CSR_W-1:0]     csr_wr_data
);

   localparam int FIDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int OCC_W  = $clog2(FRAMES + 1);

   // The chain is a recency stack: cell 0 holds the most recent page, cell k the
   // page of rank k. Each cell keeps a page and the physical frame it sits in.
   // A reference loads a new head entry and every cell above the touched position
   // takes its upper neighbor's entry in the same cycle.

   logic                       accept;
   logic [PAGE_BITS-1:0]       key;
   logic [FRAMES-1:0]          match;
   logic [FRAMES-1:0]          seen_before;
   logic [PAGE_BITS-1:0]       cell_page  [FRAMES];
   logic [FIDX_W-1:0]          cell_frame [FRAMES];
   lpr_pkg::cell_ctl_type      ctl        [FRAMES];

   logic [lpr_pkg::CSR_W-1:0]  limit_ff, limit_in;
   logic [OCC_W-1:0]           eff_limit;
   logic [OCC_W-1:0]           occ_ff, occ_in;
   logic [lpr_pkg::INDEX_W-1:0] count_ff, count_in;

   logic                       hit;
   logic                       full;
   logic [FIDX_W-1:0]          hit_frame;
   logic [FIDX_W-1:0]          tail_idx;
   logic [FIDX_W-1:0]          evict_frame;
   logic [FIDX_W-1:0]          new_frame;
   logic [OCC_W-1:0]           last_pos;

   logic                          valid_ff, valid_in;
   logic                          hit_ff, hit_in;
   logic                          evicted_ff, evicted_in;
   logic                          fvalid_ff, fvalid_in;
   logic [lpr_pkg::FRAME_W-1:0]   frame_ff, frame_in;
   logic [lpr_pkg::INDEX_W-1:0]   index_ff, index_in;
   logic [lpr_pkg::PAGE_W-1:0]    pout_ff, pout_in;

   // handshake: the output register frees up whenever it is empty or draining;
   // nothing is taken while reset is high
   assign req_stall = reset || (valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   // page is taken in its low PAGE_BITS bits
   assign key = PAGE_BITS'(req_page);

   // frame limit, clamped to 1..FRAMES
   assign limit_in = csr_wr_en ? csr_wr_data : limit_ff;

   always_comb begin
      if (limit_ff == '0) begin
         eff_limit = OCC_W'(1);
      end else if (int'(limit_ff) > FRAMES) begin
         eff_limit = OCC_W'(FRAMES);
      end else begin
         eff_limit = OCC_W'(limit_ff);
      end
   end

   // pages are unique among live cells, so match is one-hot or zero
   assign hit  = |match;
   // also covers a limit lowered below current occupancy
   assign full = (occ_ff >= eff_limit);

   always_comb begin
      hit_frame = '0;
      for (int i = 0; i < FRAMES; i++) begin
         hit_frame = hit_frame | (match[i] ? cell_frame[i] : '0);
      end
   end

   // least recent entry sits at the tail of the live region
   assign tail_idx    = FIDX_W'(occ_ff - OCC_W'(1));
   assign evict_frame = cell_frame[tail_idx];

   always_comb begin
      if (hit) begin
         new_frame = hit_frame;
      end else if (full) begin
         new_frame = evict_frame;
      end else begin
         new_frame = occ_ff[FIDX_W-1:0];   // next free frame in fill order
      end
   end

   // on a miss the shift runs through the tail (evict) or one past it (fill)
   assign last_pos = full ? (occ_ff - OCC_W'(1)) : occ_ff;

   for (genvar i = 0; i < FRAMES; i++) begin : g_cell
      localparam logic [FRAMES-1:0] LOW_MASK = (FRAMES'(1) << i) - FRAMES'(1);

      assign seen_before[i] = |(match & LOW_MASK);
      assign ctl[i].live    = (OCC_W'(i) < occ_ff);
      assign ctl[i].load    = accept &&
                              (hit ? !seen_before[i] : (OCC_W'(i) <= last_pos));

      if (i == 0) begin : g_head
         lpr_cell #(
            .PAGE_BITS (PAGE_BITS),
            .FIDX_W    (FIDX_W)
         ) u_cell (
            .clock    (clock),
            .ctl      (ctl[i]),
            .key      (key),
            .up_page  (key),
            .up_frame (new_frame),
            .match    (match[i]),
            .page     (cell_page[i]),
            .frame    (cell_frame[i])
         );
      end else begin : g_body
         lpr_cell #(
            .PAGE_BITS (PAGE_BITS),
            .FIDX_W    (FIDX_W)
         ) u_cell (
            .clock    (clock),
            .ctl      (ctl[i]),
            .key      (key),
            .up_page  (cell_page[i-1]),
            .up_frame (cell_frame[i-1]),
            .match    (match[i]),
            .page     (cell_page[i]),
            .frame    (cell_frame[i])
         );
      end
   end

   // occupancy grows only on a fill
   assign occ_in   = (accept && !hit && !full) ? (occ_ff + OCC_W'(1)) : occ_ff;
   assign count_in = accept ? (count_ff + lpr_pkg::INDEX_W'(1)) : count_ff;

   // result word
   assign valid_in   = accept ? 1'b1 : (rsp_stall ? valid_ff : 1'b0);
   assign hit_in     = accept ? hit : hit_ff;
   assign evicted_in = accept ? (!hit && full) : evicted_ff;
   assign fvalid_in  = accept ? !hit : fvalid_ff;
   assign frame_in   = accept ? (hit ? '0 : lpr_pkg::FRAME_W'(new_frame)) : frame_ff;
   assign index_in   = accept ? count_ff : index_ff;
   assign pout_in    = accept ? lpr_pkg::PAGE_W'(key) : pout_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= lpr_pkg::LIMIT_RESET;
         occ_ff   <= '0;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         limit_ff <= limit_in;
         occ_ff   <= occ_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_ff     <= hit_in;
      evicted_ff <= evicted_in;
      fvalid_ff  <= fvalid_in;
      frame_ff   <= frame_in;
      index_ff   <= index_in;
      pout_ff    <= pout_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_hit           = hit_ff;
   assign rsp_evicted       = evicted_ff;
   assign rsp_frame_valid   = fvalid_ff;
   assign rsp_frame         = frame_ff;
   assign rsp_request_index = index_ff;
   assign rsp_page_out      = pout_ff;

endmodule

FILE: sv/lpr_checker.sv
module lpr_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic                          rsp_hit,
   input  logic                          rsp_evicted,
   input  logic                          rsp_frame_valid,
   input  logic [lpr_pkg::FRAME_W-1:0]   rsp_frame,
   input  logic [lpr_pkg::INDEX_W-1:0]   rsp_request_index,
   input  logic [lpr_pkg::PAGE_W-1:0]    rsp_page_out
);

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_request_index)
                                 && $stable(rsp_page_out) && $stable(rsp_frame))
      else $error("stalled result word changed");

   // an accepted request shows up as a result word on the next cycle
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted request produced no result word");

   // no new request while a result is blocked
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("request taken while result blocked");

   // a hit touches no frame
   a_hit_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> !rsp_evicted && !rsp_frame_valid && (rsp_frame == '0))
      else $error("hit word carries frame or eviction");

   // every miss loads a frame
   a_miss_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_frame_valid)
      else $error("miss word without frame");

endmodule

bind lru_page_replacement lpr_checker u_lpr_checker (.*);

FILE: test/tb_lru_page_replacement.sv
`timescale 1ns / 1ps
module tb_lru_page_replacement;
   import lpr_pkg::*;

   // Run limits and phase sizing.
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_WORDS = 155;
   localparam int HOLD_CYCLES = 150;

   // Expected response word, one field per response port.
   typedef struct packed {
      logic               hit;
      logic               evicted;
      logic               frame_valid;
      logic [FRAME_W-1:0] frame;
      logic [INDEX_W-1:0] index;
      logic [PAGE_W-1:0]  page;
   } page_result_t;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [PAGE_W-1:0]  req_page = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_hit;
   logic               rsp_evicted;
   logic               rsp_frame_valid;
   logic [FRAME_W-1:0] rsp_frame;
   logic [INDEX_W-1:0] rsp_request_index;
   logic [PAGE_W-1:0]  rsp_page_out;
   logic               csr_wr_en = 1'b0;
   logic [CSR_W-1:0]   csr_wr_data = '0;

   // Page references waiting to be sent, and responses still owed by the block.
   logic [PAGE_W-1:0] page_queue[$];
   page_result_t      pending_results[$];

   int errors = 0;
   int cycle_count = 0;
   bit quiet = 1'b0;        // set for the last phase: no idling on either side
   int send_gap = 0;
   int stall_left = 0;
   int hold_left = 0;
   int holds_asked = 0;     // bumped by the sequencer to request a long receiver hold
   int holds_served = 0;

   // Shadow copy of the frame table: resident page and recency per frame.
   // Rank 0 is the most recent, occupied-1 the least recent.
   logic [PAGE_W-1:0]  shadow_page[FRAMES_DEF];
   logic [FRAME_W-1:0] shadow_rank[FRAMES_DEF];
   int                 shadow_occupied = 0;
   logic [INDEX_W-1:0] shadow_count = '0;
   logic [CSR_W-1:0]   shadow_limit = LIMIT_RESET;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   lru_page_replacement uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_page          (req_page),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_hit           (rsp_hit),
      .rsp_evicted       (rsp_evicted),
      .rsp_frame_valid   (rsp_frame_valid),
      .rsp_frame         (rsp_frame),
      .rsp_request_index (rsp_request_index),
      .rsp_page_out      (rsp_page_out),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   // Append one page reference to the send queue.
   function automatic void queue_page(input logic [PAGE_W-1:0] pg);
      page_queue.insert(page_queue.size(), pg);
   endfunction

   // Move frame f to the front; every occupied frame newer than old_rank ages by one.
   function automatic void make_most_recent(input int f, input int old_rank);
      for (int i = 0; i < shadow_occupied; i++) begin
         if (i != f && int'(shadow_rank[i]) < old_rank) shadow_rank[i]++;
      end
      shadow_rank[f] = '0;
   endfunction

   // One page reference against the shadow table; returns the response it should produce.
   function automatic page_result_t lru_lookup(input logic [PAGE_W-1:0] pg);
      page_result_t r;
      int           lim;
      int           f;
      int           oldest;
      bit           found;
      lim = int'(shadow_limit);
      if (lim < 1) lim = 1;
      if (lim > FRAMES_DEF) lim = FRAMES_DEF;
      f = 0;
      found = 1'b0;
      r = '0;
      for (int i = 0; i < shadow_occupied; i++) begin
         if (!found && shadow_page[i] == pg) begin
            found = 1'b1;
            f = i;
         end
      end
      if (found) begin
         make_most_recent(f, int'(shadow_rank[f]));
      end else if (shadow_occupied < lim) begin
         // free frame: fill in order 0, 1, 2, ...
         f = shadow_occupied;
         shadow_page[f] = pg;
         shadow_occupied++;
         make_most_recent(f, shadow_occupied);
      end else begin
         // full (or limit lowered under occupancy): replace LRU of all occupied frames
         oldest = 0;
         for (int i = 0; i < shadow_occupied; i++) begin
            if (int'(shadow_rank[i]) >= oldest) begin
               oldest = int'(shadow_rank[i]);
               f = i;
            end
         end
         shadow_page[f] = pg;
         r.evicted = 1'b1;
         make_most_recent(f, shadow_occupied);
      end
      r.hit = found;
      r.frame_valid = !found;
      r.frame = found ? '0 : FRAME_W'(f);
      r.index = shadow_count;
      r.page = pg;
      shadow_count++;
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      errors++;
   endtask

   // Request driver: a word stays up until taken; gaps only between words.
   always @(posedge clock) begin
      logic next_valid;
      next_valid = req_valid;
      if (reset) begin
         next_valid = 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            pending_results.insert(pending_results.size(), lru_lookup(req_page));
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
               send_gap = $urandom_range(0, 11);
            end else if (page_queue.size() != 0) begin
               req_page <= page_queue[0];
               page_queue.delete(0);
               next_valid = 1'b1;
            end
         end
      end
      req_valid <= next_valid;
   end

   // Response stall: random short bursts, plus the long hold the sequencer asks for.
   always @(posedge clock) begin
      logic next_stall;
      if (hold_left > 0) begin
         hold_left--;
         next_stall = 1'b1;
      end else if (holds_served != holds_asked) begin
         holds_served++;
         hold_left = HOLD_CYCLES - 1;
         next_stall = 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         next_stall = 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(0, 11);
         next_stall = 1'b1;
      end else begin
         next_stall = 1'b0;
      end
      rsp_stall <= next_stall;
   end

   // Response monitor: each taken word against the oldest expectation.
   always @(posedge clock) begin
      page_result_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("response with none expected (index %0d)",
                                      rsp_request_index));
         end else begin
            want = pending_results[0];
            pending_results.delete(0);
            if (rsp_hit !== want.hit)
               report_mismatch($sformatf("index %0d hit %b want %b",
                                         want.index, rsp_hit, want.hit));
            if (rsp_evicted !== want.evicted)
               report_mismatch($sformatf("index %0d evicted %b want %b",
                                         want.index, rsp_evicted, want.evicted));
            if (rsp_frame_valid !== want.frame_valid)
               report_mismatch($sformatf("index %0d frame_valid %b want %b",
                                         want.index, rsp_frame_valid, want.frame_valid));
            if (rsp_frame !== want.frame)
               report_mismatch($sformatf("index %0d frame %0d want %0d",
                                         want.index, rsp_frame, want.frame));
            if (rsp_request_index !== want.index)
               report_mismatch($sformatf("request_index %0d want %0d",
                                         rsp_request_index, want.index));
            if (rsp_page_out !== want.page)
               report_mismatch($sformatf("index %0d page_out %0d want %0d",
                                         want.index, rsp_page_out, want.page));
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Checked on the falling edge so that every update of the rising edge has landed.
   task automatic wait_drained();
      @(negedge clock);
      while (page_queue.size() != 0 || req_valid || pending_results.size() != 0)
         @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   // Limit writes only with the block idle; the shadow copy follows at once.
   task automatic write_limit(input logic [CSR_W-1:0] value);
      wait_drained();
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      shadow_limit = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Sequencer.
   initial begin
      int limits[$];
      int ws_base;
      int ws_size;
      limits = '{8, 1, 2, 15, 5, 0, 3, 9, 7, 4, 6, 8};
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Limit 0 behaves as one frame: fill, hit, replace in place, then hit again.
      write_limit(4'd0);
      queue_page(8'd0);
      queue_page(8'd0);
      queue_page(8'd255);
      queue_page(8'd255);
      // Three frames: fill frames 1 and 2, then evict the oldest.
      write_limit(4'd3);
      queue_page(8'd1);
      queue_page(8'd2);
      queue_page(8'd0);
      // Limit above the frame count acts as the frame count: fill the rest, hit twice, then evict.
      write_limit(4'd15);
      queue_page(8'd170);
      queue_page(8'd85);
      queue_page(8'd3);
      queue_page(8'd4);
      queue_page(8'd5);
      queue_page(8'd1);
      queue_page(8'd85);
      queue_page(8'd128);
      // Limit dropped under occupancy: misses replace LRU of all eight frames.
      write_limit(4'd2);
      queue_page(8'd127);
      queue_page(8'd128);
      queue_page(8'd64);
      queue_page(8'd127);
      queue_page(8'd170);

      // Random phases: mostly a small working set so hits and LRU order matter,
      // with some references anywhere in the page space.
      foreach (limits[p]) begin
         write_limit(CSR_W'(limits[p]));
         if (p == limits.size() - 1) quiet = 1'b1;
         ws_base = $urandom_range(0, 255);
         ws_size = $urandom_range(2, 12);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            if ($urandom_range(0, 9) < 7)
               queue_page(PAGE_W'(ws_base + $urandom_range(0, ws_size - 1)));
            else
               queue_page(PAGE_W'($urandom_range(0, 255)));
         end
         // long receiver hold while requests keep coming: block backs up
         if (p == 2 || p == 7) holds_asked++;
         // sender waits out every owed response before the next phase
         wait_drained();
      end

      repeat (4) @(posedge clock);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

FILE: sim.f
sv/lpr_pkg.sv
sv/lpr_cell.sv
sv/lru_page_replacement.sv
sv/lpr_checker.sv
test/tb_lru_page_replacement.sv
